// ----- rtl/core/ptm_pkg.sv -----
package ptm_pkg;

    // Field widths of the command and result items.
    localparam int ADDR_W   = 52;
    localparam int VA_W     = 64;
    localparam int WORD_W   = 64;
    localparam int PFN_W    = 40;
    localparam int SLOT_W   = 9;
    localparam int ENTRIES  = 512;
    localparam int RFRAME_W = 6;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 7;

    // Parameter defaults.
    localparam int DEF_TABLE_FRAMES = 64;
    localparam int DEF_LEVELS       = 4;

    // Page table entry bit positions.
    localparam int PTE_PRESENT_BIT = 0;
    localparam int PTE_WRITE_BIT   = 1;
    localparam int PTE_LARGE_BIT   = 7;
    localparam int PTE_GLOBAL_BIT  = 8;
    localparam int PTE_NX_BIT      = 63;
    localparam int PTE_ADDR_LO     = 12;

    // First virtual-address bit at and above which every bit must be set for the upper half.
    localparam int UPPER_HALF_LO = 47;

    // Command codes.
    localparam logic CMD_MAP  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MAPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_ROOM = 2'd2;

    // Request to the shared page-frame-number adder.
    typedef struct packed {
        logic             sub;
        logic [PFN_W-1:0] a;
        logic [PFN_W-1:0] b;
    } pfn_req_t;

endpackage

// ----- rtl/core/ptm_store.sv -----
module ptm_store #(
    parameter int DEPTH = ptm_pkg::DEF_TABLE_FRAMES * ptm_pkg::ENTRIES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [ptm_pkg::WORD_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [ptm_pkg::WORD_W-1:0] rdata
);

    // Table frames, one entry per 64-bit table word.
    logic [ptm_pkg::WORD_W-1:0] mem [DEPTH];
    logic [ptm_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/ptm_pfn_unit.sv -----
module ptm_pfn_unit (
    input  ptm_pkg::pfn_req_t          req,
    output logic [ptm_pkg::PFN_W-1:0]  result
);

    // Page frame numbers wrap modulo the 40-bit address field, as the
    // entry address mask does.
    always_comb
    begin
        if (req.sub)
        begin
            result = req.a - req.b;
        end
        else
        begin
            result = req.a + req.b;
        end
    end

endmodule

// ----- rtl/core/page_table_map_engine.sv -----
// Page table map engine. The block keeps TABLE_FRAMES table frames of 512 64-bit
// words in one internal memory; frame 0 is the root and frame f sits at physical
// address table_base + f * 4 KiB. A map command (cmd = 0) walks from level
// LEVELS-1 down to level 1 for a 2 MiB page (large_req = 1) or to level 0 for a
// 4 KiB page, using nine virtual-address bits per level. A missing table is taken
// from the next free frame and linked with present and writable set; the leaf
// gets the page address plus present, writable, no-execute, global (upper half)
// and large bits. An already-present leaf, or a present entry on the path that
// does not point at an allocated frame, returns status 1 with nothing more
// written; running out of frames returns status 2 with no leaf write, while
// tables linked earlier in the same walk stay allocated. A read command (cmd = 1)
// returns the word at read_frame/read_slot, or zero for a frame beyond the store.
// Every result also carries frames_used, the low seven bits of the allocation
// count. Steps: each level of the walk is a memory read state and a check state
// sharing one 40-bit adder, followed by a leaf read and a leaf check; a read
// command waits for the memory read and then finishes. One command is in
// flight at a time; the result sits in an output register, and a new command is
// taken as soon as the engine is back in its idle state. After reset the engine
// runs a clearing pass that zeroes all TABLE_FRAMES * 512 memory words (32768
// with the default of 64 frames), one word per cycle; no command is taken during
// it, but table_base writes are. Write table_base only while the engine is idle.
module page_table_map_engine #(
    parameter int TABLE_FRAMES = ptm_pkg::DEF_TABLE_FRAMES,
    parameter int LEVELS       = ptm_pkg::DEF_LEVELS
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_we,
    input  logic [ptm_pkg::ADDR_W-1:0]   cfg_wdata,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic [ptm_pkg::ADDR_W-1:0]   phys_addr,
    input  logic [ptm_pkg::VA_W-1:0]     virt_addr,
    input  logic                         writeable,
    input  logic                         executable,
    input  logic                         large_req,
    input  logic [ptm_pkg::RFRAME_W-1:0] read_frame,
    input  logic [ptm_pkg::SLOT_W-1:0]   read_slot,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ptm_pkg::STATUS_W-1:0] status,
    output logic [ptm_pkg::WORD_W-1:0]   word,
    output logic [ptm_pkg::USED_W-1:0]   frames_used
);

    localparam int DEPTH = TABLE_FRAMES * ptm_pkg::ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int NW    = $clog2(TABLE_FRAMES + 1);
    localparam int LW    = $clog2(LEVELS);

    localparam int PFN_W  = ptm_pkg::PFN_W;
    localparam int WORD_W = ptm_pkg::WORD_W;
    localparam int SLOT_W = ptm_pkg::SLOT_W;
    localparam int LO     = ptm_pkg::PTE_ADDR_LO;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_RD_WAIT  = 3'd2;
    localparam logic [2:0] S_WALK_RD  = 3'd3;
    localparam logic [2:0] S_WALK_CHK = 3'd4;
    localparam logic [2:0] S_LEAF_RD  = 3'd5;
    localparam logic [2:0] S_LEAF_CHK = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    // Control state.
    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [NW-1:0] next_free_reg, next_free_next;
    logic          out_valid_reg, out_valid_next;
    logic [ptm_pkg::ADDR_W-1:0] table_base_reg;

    // Command being worked on.
    logic [ptm_pkg::VA_W-1:0]   va_reg, va_next;
    logic [ptm_pkg::ADDR_W-1:0] pa_reg, pa_next;
    logic                       wr_reg, wr_next;
    logic                       ex_reg, ex_next;
    logic                       large_reg, large_next;
    logic                       rd_ok_reg, rd_ok_next;
    logic [FW-1:0]              frame_reg, frame_next;
    logic [LW-1:0]              lvl_reg, lvl_next;

    // Result staging and output registers.
    logic [ptm_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [WORD_W-1:0]            res_word_reg, res_word_next;
    logic [ptm_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [WORD_W-1:0]            word_reg, word_next;
    logic [ptm_pkg::USED_W-1:0]   used_reg, used_next;

    // Memory port and shared adder.
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;
    ptm_pkg::pfn_req_t pfn_req;
    logic [PFN_W-1:0]  pfn_result;

    logic [SLOT_W-1:0] vidx;
    logic [AW-1:0]     node_addr;
    logic [AW-1:0]     cmd_addr;
    logic [LW-1:0]     lvl_dn;
    logic [LW-1:0]     target;
    logic [LW-1:0]     top_lvl;
    logic              entry_present;
    logic [WORD_W-1:0] leaf;

    assign target    = LW'(large_reg);
    assign top_lvl   = LW'(LEVELS - 1);
    assign lvl_dn    = lvl_reg - LW'(1);
    assign vidx      = va_reg[LO + SLOT_W * lvl_reg +: SLOT_W];
    assign node_addr = AW'({frame_reg, vidx});
    assign cmd_addr  = AW'({read_frame, read_slot});
    assign entry_present = mem_rdata[ptm_pkg::PTE_PRESENT_BIT];

    ptm_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // A present entry is decoded back to a frame number relative to
    // table_base; a new link is table_base plus the allocated frame number.
    always_comb
    begin
        pfn_req.sub = entry_present;
        if (entry_present)
        begin
            pfn_req.a = mem_rdata[LO +: PFN_W];
            pfn_req.b = table_base_reg[LO +: PFN_W];
        end
        else
        begin
            pfn_req.a = table_base_reg[LO +: PFN_W];
            pfn_req.b = PFN_W'(next_free_reg);
        end
    end

    ptm_pfn_unit u_pfn (
        .req    (pfn_req),
        .result (pfn_result)
    );

    // Leaf entry for the command in flight.
    always_comb
    begin
        leaf = '0;
        leaf[LO +: PFN_W] = pa_reg[LO +: PFN_W];
        leaf[ptm_pkg::PTE_PRESENT_BIT] = 1'b1;
        leaf[ptm_pkg::PTE_WRITE_BIT]   = wr_reg;
        leaf[ptm_pkg::PTE_NX_BIT]      = ~ex_reg;
        leaf[ptm_pkg::PTE_GLOBAL_BIT]  = &va_reg[ptm_pkg::VA_W-1:ptm_pkg::UPPER_HALF_LO];
        leaf[ptm_pkg::PTE_LARGE_BIT]   = large_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        next_free_next  = next_free_reg;
        out_valid_next  = out_valid_reg;
        va_next         = va_reg;
        pa_next         = pa_reg;
        wr_next         = wr_reg;
        ex_next         = ex_reg;
        large_next      = large_reg;
        rd_ok_next      = rd_ok_reg;
        frame_next      = frame_reg;
        lvl_next        = lvl_reg;
        res_status_next = res_status_reg;
        res_word_next   = res_word_reg;
        status_next     = status_reg;
        word_next       = word_reg;
        used_next       = used_reg;

        mem_we    = 1'b0;
        mem_waddr = node_addr;
        mem_wdata = leaf;
        mem_raddr = node_addr;
        in_ready  = 1'b0;

        // The result leaves the output register on its transfer.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                in_ready  = 1'b1;
                mem_raddr = cmd_addr;
                if (in_valid)
                begin
                    va_next    = virt_addr;
                    pa_next    = phys_addr;
                    wr_next    = writeable;
                    ex_next    = executable;
                    large_next = large_req;
                    frame_next = '0;
                    lvl_next   = top_lvl;
                    rd_ok_next = 32'(read_frame) < TABLE_FRAMES;
                    if (cmd == ptm_pkg::CMD_READ)
                    begin
                        state_next = S_RD_WAIT;
                    end
                    else if (top_lvl > LW'(large_req))
                    begin
                        state_next = S_WALK_RD;
                    end
                    else
                    begin
                        state_next = S_LEAF_RD;
                    end
                end
            end

            S_RD_WAIT:
            begin
                res_status_next = ptm_pkg::STATUS_OK;
                res_word_next   = rd_ok_reg ? mem_rdata : '0;
                state_next      = S_FINISH;
            end

            S_WALK_RD:
            begin
                state_next = S_WALK_CHK;
            end

            S_WALK_CHK:
            begin
                if (!entry_present)
                begin
                    if (next_free_reg >= NW'(TABLE_FRAMES))
                    begin
                        res_status_next = ptm_pkg::STATUS_NO_ROOM;
                        res_word_next   = '0;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        // Link a fresh frame; it is still zero from the
                        // clearing pass, since frames are never reused.
                        mem_we    = 1'b1;
                        mem_wdata = '0;
                        mem_wdata[LO +: PFN_W] = pfn_result;
                        mem_wdata[ptm_pkg::PTE_PRESENT_BIT] = 1'b1;
                        mem_wdata[ptm_pkg::PTE_WRITE_BIT]   = 1'b1;
                        next_free_next = next_free_reg + NW'(1);
                        frame_next     = FW'(next_free_reg);
                        lvl_next       = lvl_dn;
                        state_next     = (lvl_dn > target) ? S_WALK_RD : S_LEAF_RD;
                    end
                end
                else if (pfn_result >= PFN_W'(next_free_reg))
                begin
                    // Present, but not one of our tables (a large leaf, say).
                    res_status_next = ptm_pkg::STATUS_MAPPED;
                    res_word_next   = '0;
                    state_next      = S_FINISH;
                end
                else
                begin
                    frame_next = FW'(pfn_result);
                    lvl_next   = lvl_dn;
                    state_next = (lvl_dn > target) ? S_WALK_RD : S_LEAF_RD;
                end
            end

            S_LEAF_RD:
            begin
                state_next = S_LEAF_CHK;
            end

            S_LEAF_CHK:
            begin
                if (entry_present)
                begin
                    res_status_next = ptm_pkg::STATUS_MAPPED;
                    res_word_next   = '0;
                end
                else
                begin
                    mem_we          = 1'b1;
                    res_status_next = ptm_pkg::STATUS_OK;
                    res_word_next   = leaf;
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    word_next      = res_word_reg;
                    used_next      = ptm_pkg::USED_W'(next_free_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            next_free_reg  <= NW'(1);
            out_valid_reg  <= 1'b0;
            table_base_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            next_free_reg <= next_free_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                table_base_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg         <= va_next;
        pa_reg         <= pa_next;
        wr_reg         <= wr_next;
        ex_reg         <= ex_next;
        large_reg      <= large_next;
        rd_ok_reg      <= rd_ok_next;
        frame_reg      <= frame_next;
        lvl_reg        <= lvl_next;
        res_status_reg <= res_status_next;
        res_word_reg   <= res_word_next;
        status_reg     <= status_next;
        word_reg       <= word_next;
        used_reg       <= used_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign word        = word_reg;
    assign frames_used = used_reg;

endmodule

// ----- verif/page_table_map_engine_checker.sv -----
`timescale 1ns / 1ps
module page_table_map_engine_checker
    import ptm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [ADDR_W-1:0]     cfg_wdata,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  cmd,
    input  logic [ADDR_W-1:0]     phys_addr,
    input  logic [VA_W-1:0]       virt_addr,
    input  logic                  writeable,
    input  logic                  executable,
    input  logic                  large_req,
    input  logic [RFRAME_W-1:0]   read_frame,
    input  logic [SLOT_W-1:0]     read_slot,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [STATUS_W-1:0]   status,
    input  logic [WORD_W-1:0]     word,
    input  logic [USED_W-1:0]     frames_used,
    output int                    fail_count,
    output int                    outstanding
);

    localparam int FRAMES      = DEF_TABLE_FRAMES;
    localparam int WALK_LEVELS = DEF_LEVELS;

    localparam logic [WORD_W-1:0] PTE_ADDR_MASK =
        {{(WORD_W - PTE_ADDR_LO - PFN_W){1'b0}}, {PFN_W{1'b1}}, {PTE_ADDR_LO{1'b0}}};
    localparam logic [WORD_W-1:0] PTE_P  = WORD_W'(1) << PTE_PRESENT_BIT;
    localparam logic [WORD_W-1:0] PTE_RW = WORD_W'(1) << PTE_WRITE_BIT;
    localparam logic [WORD_W-1:0] PTE_PS = WORD_W'(1) << PTE_LARGE_BIT;
    localparam logic [WORD_W-1:0] PTE_G  = WORD_W'(1) << PTE_GLOBAL_BIT;
    localparam logic [WORD_W-1:0] PTE_XD = WORD_W'(1) << PTE_NX_BIT;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   word;
        logic [USED_W-1:0]   used;
    } table_result_t;

    logic [WORD_W-1:0] table_words [FRAMES * ENTRIES];
    int unsigned       next_frame;
    logic [ADDR_W-1:0] base_reg;
    table_result_t     expected_results [$];
    int                err_count;

    initial
    begin
        foreach (table_words[i])
            table_words[i] = '0;
        next_frame = 1;
        base_reg   = '0;
        err_count  = 0;
    end

    function automatic logic [WORD_W-1:0] frame_location(input int unsigned f);
        return ((WORD_W'(base_reg) & PTE_ADDR_MASK) + (WORD_W'(f) << PTE_ADDR_LO))
               & PTE_ADDR_MASK;
    endfunction

    // Applies one command to the shadow tables and returns the result it should produce.
    function automatic table_result_t apply_command(
        input logic              c,
        input logic [ADDR_W-1:0] pa,
        input logic [VA_W-1:0]   va,
        input logic              wr,
        input logic              ex,
        input logic              lg,
        input logic [RFRAME_W-1:0] rf,
        input logic [SLOT_W-1:0] rs
    );
        table_result_t     res;
        logic [WORD_W-1:0] ent;
        logic [WORD_W-1:0] rel;
        logic [WORD_W-1:0] leaf;
        int unsigned       lvl;
        int unsigned       target;
        int unsigned       frame;
        int unsigned       slot;
        int unsigned       nf;
        int unsigned       w;
        logic              stop;

        res.status = STATUS_OK;
        res.word   = '0;
        stop       = 1'b0;
        frame      = 0;
        if (c == CMD_READ)
        begin
            res.word = table_words[rf * ENTRIES + rs];
        end
        else
        begin
            target = lg ? 1 : 0;
            for (lvl = WALK_LEVELS - 1; lvl > target && !stop; lvl--)
            begin
                slot = frame * ENTRIES + va[PTE_ADDR_LO + SLOT_W * lvl +: SLOT_W];
                ent  = table_words[slot];
                if (!ent[PTE_PRESENT_BIT])
                begin
                    if (next_frame >= FRAMES)
                    begin
                        res.status = STATUS_NO_ROOM;
                        stop       = 1'b1;
                    end
                    else
                    begin
                        nf = next_frame;
                        next_frame++;
                        for (w = 0; w < ENTRIES; w++)
                            table_words[nf * ENTRIES + w] = '0;
                        table_words[slot] = frame_location(nf) | PTE_P | PTE_RW;
                        frame = nf;
                    end
                end
                else
                begin
                    // A present entry is only followed if it decodes to an allocated frame.
                    rel = ((ent & PTE_ADDR_MASK) - (WORD_W'(base_reg) & PTE_ADDR_MASK))
                          & PTE_ADDR_MASK;
                    if ((rel >> PTE_ADDR_LO) >= next_frame || (rel >> PTE_ADDR_LO) >= FRAMES)
                    begin
                        res.status = STATUS_MAPPED;
                        stop       = 1'b1;
                    end
                    else
                        frame = int'(rel >> PTE_ADDR_LO);
                end
            end
            if (!stop)
            begin
                slot = frame * ENTRIES + va[PTE_ADDR_LO + SLOT_W * target +: SLOT_W];
                if (table_words[slot][PTE_PRESENT_BIT])
                    res.status = STATUS_MAPPED;
                else
                begin
                    leaf = (WORD_W'(pa) & PTE_ADDR_MASK) | PTE_P;
                    if (wr)
                        leaf |= PTE_RW;
                    if (!ex)
                        leaf |= PTE_XD;
                    if (&va[VA_W-1:UPPER_HALF_LO])
                        leaf |= PTE_G;
                    if (lg)
                        leaf |= PTE_PS;
                    table_words[slot] = leaf;
                    res.word = leaf;
                end
            end
        end
        res.used = USED_W'(next_frame);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    always @(posedge clk)
    begin : watch
        table_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing outstanding", word, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", WORD_W'(status), WORD_W'(want.status));
                    if (word !== want.word)
                        report_mismatch("word", word, want.word);
                    if (frames_used !== want.used)
                        report_mismatch("frames_used", WORD_W'(frames_used), WORD_W'(want.used));
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_command(cmd, phys_addr, virt_addr, writeable,
                                                         executable, large_req, read_frame,
                                                         read_slot));
            if (cfg_we)
                base_reg = cfg_wdata;
        end
        outstanding <= expected_results.size();
        fail_count  <= err_count;
    end

endmodule

// ----- verif/page_table_map_engine_tb.sv -----
`timescale 1ns / 1ps
module page_table_map_engine_tb;
    import ptm_pkg::*;

    // Generous cycle budget, which must also cover the clearing pass after reset.
    localparam int LIMIT_CYCLES    = 600000;
    // Cycles left to the engine after the last result before the base is changed.
    localparam int DRAIN_CYCLES    = 24;
    // Length of the receiver hold-off used to back the engine up.
    localparam int HOLD_OFF_CYCLES = 300;

    localparam logic [ADDR_W-1:0] BASE_TOP      = '1;
    // Only the low twelve bits are set, so the effective base stays at zero.
    localparam logic [ADDR_W-1:0] BASE_LOW_JUNK = 52'h0000000000ABC;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                cfg_we     = 1'b0;
    logic [ADDR_W-1:0]   cfg_wdata  = '0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic                cmd        = CMD_MAP;
    logic [ADDR_W-1:0]   phys_addr  = '0;
    logic [VA_W-1:0]     virt_addr  = '0;
    logic                writeable  = 1'b0;
    logic                executable = 1'b0;
    logic                large_req  = 1'b0;
    logic [RFRAME_W-1:0] read_frame = '0;
    logic [SLOT_W-1:0]   read_slot  = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   word;
    logic [USED_W-1:0]   frames_used;

    int   fail_count;
    int   outstanding;

    // Idle rates in percent of cycles; the sender rate is only used by the stimulus process.
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    // Each toggle asks the receiver process for one long hold-off.
    logic hold_off_req  = 1'b0;

    // Recently mapped virtual addresses, replayed to provoke already-mapped results.
    logic [VA_W-1:0] mapped_vas [$];

    page_table_map_engine i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .phys_addr   (phys_addr),
        .virt_addr   (virt_addr),
        .writeable   (writeable),
        .executable  (executable),
        .large_req   (large_req),
        .read_frame  (read_frame),
        .read_slot   (read_slot),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .word        (word),
        .frames_used (frames_used)
    );

    page_table_map_engine_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .phys_addr   (phys_addr),
        .virt_addr   (virt_addr),
        .writeable   (writeable),
        .executable  (executable),
        .large_req   (large_req),
        .read_frame  (read_frame),
        .read_slot   (read_slot),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .word        (word),
        .frames_used (frames_used),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // The run is cut off if it has not finished within the cycle budget.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // The receiver accepts results at random according to recv_idle_pct. When a hold-off
    // is requested it keeps out_ready low for a long stretch, counting the cycles itself.
    initial
    begin : receiver
        logic hold_seen;
        int   hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req != hold_seen)
            begin
                hold_seen = hold_off_req;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [ADDR_W-1:0] random_phys();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    // Table indexes are mostly drawn from a few values per level so that walks share
    // tables and reach deep; now and then a fully random index allocates fresh frames.
    function automatic logic [SLOT_W-1:0] pooled_index(input int unsigned lvl);
        int unsigned r;
        r = $urandom_range(15);
        if (r == 0)
            return SLOT_W'($urandom);
        case (r % 3)
            0:       return '0;
            1:       return '1;
            default: return SLOT_W'(lvl * 85 + 1);
        endcase
    endfunction

    function automatic logic [VA_W-1:0] shaped_va();
        logic [VA_W-1:0] va;
        int unsigned     lvl;
        va = {$urandom, $urandom};
        for (lvl = 1; lvl < DEF_LEVELS; lvl++)
            va[PTE_ADDR_LO + SLOT_W * lvl +: SLOT_W] = pooled_index(lvl);
        // Mostly canonical addresses, so the upper half is hit often; the rest stay random.
        if ($urandom_range(4) != 0)
            va[VA_W-1:UPPER_HALF_LO+1] = {(VA_W - UPPER_HALF_LO - 1){va[UPPER_HALF_LO]}};
        return va;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of_interest();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return SLOT_W'(3 * 85 + 1);
            3:       return SLOT_W'(2 * 85 + 1);
            4:       return SLOT_W'(1 * 85 + 1);
            default: return SLOT_W'($urandom);
        endcase
    endfunction

    // Offers one command and returns at the edge where its transfer takes place. A random
    // idle gap may come first; valid is then held with a stable payload until accepted.
    task automatic offer(input logic c, input logic [ADDR_W-1:0] pa, input logic [VA_W-1:0] va,
                         input logic wr, input logic ex, input logic lg,
                         input logic [RFRAME_W-1:0] rf, input logic [SLOT_W-1:0] rs);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        phys_addr  <= pa;
        virt_addr  <= va;
        writeable  <= wr;
        executable <= ex;
        large_req  <= lg;
        read_frame <= rf;
        read_slot  <= rs;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Fields a command does not use are filled with random values anyway.
    task automatic map_page(input logic [ADDR_W-1:0] pa, input logic [VA_W-1:0] va,
                            input logic wr, input logic ex, input logic lg);
        offer(CMD_MAP, pa, va, wr, ex, lg, RFRAME_W'($urandom), SLOT_W'($urandom));
    endtask

    task automatic read_word(input logic [RFRAME_W-1:0] rf, input logic [SLOT_W-1:0] rs);
        offer(CMD_READ, random_phys(), {$urandom, $urandom}, 1'($urandom), 1'($urandom),
              1'($urandom), rf, rs);
    endtask

    task automatic random_item();
        logic [VA_W-1:0] va;
        int unsigned     pick;
        pick = $urandom_range(99);
        if (pick < 22)
        begin
            if ($urandom_range(1) == 0)
                read_word(RFRAME_W'($urandom_range(15)), slot_of_interest());
            else
                read_word(RFRAME_W'($urandom), slot_of_interest());
        end
        else
        begin
            if (mapped_vas.size() > 0 && pick < 32)
                va = mapped_vas[$urandom_range(mapped_vas.size() - 1)];
            else
                va = shaped_va();
            map_page(random_phys(), va, 1'($urandom), 1'($urandom), $urandom_range(3) == 0);
            mapped_vas.push_back(va);
            if (mapped_vas.size() > 48)
                void'(mapped_vas.pop_front());
        end
    endtask

    // Stops offering and waits until every expected result has come back, then gives
    // the engine DRAIN_CYCLES more so that it is surely idle.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_base(input logic [ADDR_W-1:0] base);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Sender idles 30 percent of the time, receiver 74 percent.
        send_idle_pct = 30;
        recv_idle_pct <= 74;

        // The base write lands during the clearing pass, which the engine allows.
        program_base('0);

        // Directed commands: empty store, first walk, repeats, extremes and the
        // interaction of 2 MiB leaves with 4 KiB walks.
        read_word('0, '0);
        map_page('0, '0, 1'b0, 1'b1, 1'b0);
        map_page('1, '0, 1'b1, 1'b0, 1'b0);
        map_page('1, '1, 1'b1, 1'b0, 1'b0);
        map_page(52'h123456789ABCD, 64'hFFFF_8000_0000_0000, 1'b1, 1'b1, 1'b0);
        map_page(random_phys(), 64'hFFFF_7FFF_FFFF_F000, 1'b0, 1'b0, 1'b0);
        map_page(random_phys(), 64'h0000_8000_0000_0000, 1'b1, 1'b1, 1'b0);
        map_page('1, 64'h0000_0000_0020_0000, 1'b0, 1'b1, 1'b1);
        // A 4 KiB walk that runs into the 2 MiB leaf just written.
        map_page(random_phys(), 64'h0000_0000_0020_3000, 1'b1, 1'b1, 1'b0);
        // A 2 MiB map where a table already sits at level 1.
        map_page(random_phys(), '0, 1'b1, 1'b1, 1'b1);
        map_page(random_phys(), 64'h0000_0000_0040_0000, 1'b1, 1'b0, 1'b1);
        read_word('0, '0);
        read_word(6'd1, '0);
        read_word(6'd3, '0);
        read_word(6'd2, 9'd1);
        read_word('1, '1);
        read_word('0, '1);

        // Low base bits set but ignored, so the tables built so far stay reachable.
        program_base(BASE_LOW_JUNK);
        repeat (400) random_item();

        // Now the other way round: the sender idles 74 percent, the receiver 30.
        send_idle_pct = 74;
        recv_idle_pct <= 30;
        program_base(BASE_TOP);
        repeat (150) random_item();
        hold_off_req <= ~hold_off_req;
        repeat (200) random_item();

        // No idling from here on. A long hold-off right away backs the engine up.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        program_base(ADDR_W'({$urandom, $urandom}));
        hold_off_req <= ~hold_off_req;
        repeat (100) random_item();

        program_base('0);
        repeat (200) random_item();

        drain();
        if (fail_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/ptm_pkg.sv
rtl/core/ptm_store.sv
rtl/core/ptm_pfn_unit.sv
rtl/core/page_table_map_engine.sv
verif/page_table_map_engine_checker.sv
verif/page_table_map_engine_tb.sv
